FILE: src/utf8_sanitizer_macros.svh
// Assertion macros for the UTF-8 sanitiser.
// Used by files that check their own logic; expects i_clk and i_rst_n in scope.
`ifndef UTF8_SANITIZER_MACROS_SVH
`define UTF8_SANITIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8S_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U8S_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/utf8s_pkg.sv
// Shared types, byte constants and lead-byte decoding for the UTF-8 sanitiser.
// No dependencies; used by the checker, the top level and the testbench.
`default_nettype none

package utf8s_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_EMIT
    } t_state;

    // Bytes of the replacement character U+FFFD.
    localparam logic [7:0] REPL_B0 = 8'hef;
    localparam logic [7:0] REPL_B1 = 8'hbf;
    localparam logic [7:0] REPL_B2 = 8'hbd;

    localparam logic [7:0] CONT_LO = 8'h80;
    localparam logic [7:0] CONT_HI = 8'hbf;

    typedef struct packed {
        logic [2:0] need;
        logic [7:0] lo;
        logic [7:0] hi;
    } t_lead;

    // Outcome of checking the sequence at the head of the window.
    typedef struct packed {
        logic       bad;
        logic       hold;
        logic [2:0] need;
    } t_verdict;

    function automatic t_lead lead_decode(input logic [7:0] lead);
        t_lead d;
        d.lo   = CONT_LO;
        d.hi   = CONT_HI;
        d.need = 3'd0;
        if (lead <= 8'h7f) begin
            d.need = 3'd1;
        end else if (lead >= 8'hc2 && lead <= 8'hdf) begin
            d.need = 3'd2;
        end else if (lead == 8'he0) begin
            d.need = 3'd3;
            d.lo   = 8'ha0;
        end else if (lead >= 8'he1 && lead <= 8'hec) begin
            d.need = 3'd3;
        end else if (lead == 8'hed) begin
            d.need = 3'd3;
            d.hi   = 8'h9f;
        end else if (lead >= 8'hee && lead <= 8'hef) begin
            d.need = 3'd3;
        end else if (lead == 8'hf0) begin
            d.need = 3'd4;
            d.lo   = 8'h90;
        end else if (lead >= 8'hf1 && lead <= 8'hf3) begin
            d.need = 3'd4;
        end else if (lead == 8'hf4) begin
            d.need = 3'd4;
            d.hi   = 8'h8f;
        end
        return d;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b >= CONT_LO) && (b <= CONT_HI);
    endfunction

endpackage

`default_nettype wire

FILE: src/utf8s_if.sv
// Valid/ready stream interfaces for the byte input and the byte output.
// No dependencies.
`default_nettype none

interface utf8s_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface utf8s_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

FILE: src/utf8s_check.sv
// Sequence checker: judges the UTF-8 sequence at the head of the byte window.
// Depends on utf8s_pkg for lead decoding and the verdict type.
`default_nettype none

module utf8s_check (
    input  wire logic [7:0]         i_win [4],
    input  wire logic [2:0]         i_cnt,
    input  wire logic               i_last,
    output utf8s_pkg::t_verdict     o_verdict
);

    utf8s_pkg::t_lead lead;
    logic             bad;

    assign lead = utf8s_pkg::lead_decode(i_win[0]);

    always_comb begin
        bad = (lead.need == 3'd0);
        if (!bad && lead.need >= 3'd2 && i_cnt >= 3'd2) begin
            bad = (i_win[1] < lead.lo) || (i_win[1] > lead.hi);
        end
        if (!bad && lead.need >= 3'd3 && i_cnt >= 3'd3) begin
            bad = !utf8s_pkg::is_cont(i_win[2]);
        end
        if (!bad && lead.need >= 3'd4 && i_cnt >= 3'd4) begin
            bad = !utf8s_pkg::is_cont(i_win[3]);
        end
        o_verdict.hold = 1'b0;
        // A sequence that is fine so far but short waits unless the string ends.
        if (!bad && i_cnt < lead.need) begin
            if (i_last) begin
                bad = 1'b1;
            end else begin
                o_verdict.hold = 1'b1;
            end
        end
        o_verdict.bad  = bad;
        o_verdict.need = lead.need;
    end

endmodule

`default_nettype wire

FILE: src/utf8_sanitizer.sv
// Top level of the streaming UTF-8 sanitiser.
// Depends on utf8s_pkg, utf8s_if, utf8s_check and utf8_sanitizer_macros.svh.
//
//  Port     | Dir | Payload            | Role
//  ---------+-----+--------------------+-------------------------------------
//  i_in     | in  | in_byte, in_last   | raw text bytes, last marks string end
//  o_out    | out | out_byte, out_last | sanitised bytes, last on final byte
//
// An input byte is taken in the idle state and checked in the next cycle; a byte
// that only joins a pending sequence then returns the block to idle. Otherwise
// each sequence resolved takes a check and then an emit state that sends its bytes
// one at a time while the output register is free (the three replacement bytes for
// a bad one), and a final check that finds nothing left to resolve ends the run.
// The single sequence checker is reused once per sequence.
// Reset (synchronous, active low) empties the window and the output register.
// A stalled output holds the emit sequence; input is refused until it is done.
`default_nettype none
`include "utf8_sanitizer_macros.svh"

module utf8_sanitizer (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    utf8s_in_if.sink   i_in,
    utf8s_out_if.source o_out
);

    // Window of unresolved bytes, oldest at index 0. r_cnt counts the valid
    // entries; between strings of work it holds the pending bytes.
    logic [7:0]          r_win [4];
    logic [7:0]          n_win [4];
    logic [2:0]          r_cnt, n_cnt;
    logic                r_last, n_last;
    utf8s_pkg::t_state   r_state, n_state;
    // Bytes still to emit for the current sequence, and whether it is the
    // replacement character rather than the original bytes.
    logic [2:0]          r_grp, n_grp;
    logic                r_repl, n_repl;
    // Output register.
    logic                r_ovalid, n_ovalid;
    logic [7:0]          r_obyte, n_obyte;
    logic                r_olast, n_olast;

    utf8s_pkg::t_verdict verdict;
    logic                slot_free;
    logic [7:0]          repl_byte;

    utf8s_check u_check (
        .i_win     (r_win),
        .i_cnt     (r_cnt),
        .i_last    (r_last),
        .o_verdict (verdict)
    );

    assign i_in.ready     = (r_state == utf8s_pkg::S_IDLE);
    assign o_out.valid    = r_ovalid;
    assign o_out.out_byte = r_obyte;
    assign o_out.out_last = r_olast;

    // The output register can be loaded when it is empty or being drained.
    assign slot_free = !r_ovalid || o_out.ready;

    always_comb begin
        unique case (r_grp)
            3'd3:    repl_byte = utf8s_pkg::REPL_B0;
            3'd2:    repl_byte = utf8s_pkg::REPL_B1;
            default: repl_byte = utf8s_pkg::REPL_B2;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_win    = r_win;
        n_cnt    = r_cnt;
        n_last   = r_last;
        n_grp    = r_grp;
        n_repl   = r_repl;
        n_ovalid = r_ovalid;
        n_obyte  = r_obyte;
        n_olast  = r_olast;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            utf8s_pkg::S_IDLE: begin
                // At most three bytes are pending here, so the new byte fits.
                if (i_in.valid) begin
                    n_win[r_cnt[1:0]] = i_in.in_byte;
                    n_cnt             = r_cnt + 3'd1;
                    n_last            = i_in.in_last;
                    n_state           = utf8s_pkg::S_CHECK;
                end
            end
            utf8s_pkg::S_CHECK: begin
                if (r_cnt == 3'd0 || verdict.hold) begin
                    n_state = utf8s_pkg::S_IDLE;
                end else if (verdict.bad) begin
                    n_repl  = 1'b1;
                    n_grp   = 3'd3;
                    n_state = utf8s_pkg::S_EMIT;
                end else begin
                    n_repl  = 1'b0;
                    n_grp   = verdict.need;
                    n_state = utf8s_pkg::S_EMIT;
                end
            end
            utf8s_pkg::S_EMIT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = r_repl ? repl_byte : r_win[0];
                    // The final byte of a string is the one that empties the window.
                    n_olast  = r_last && (r_grp == 3'd1) && (r_cnt == 3'd1);
                    // Original bytes leave the window one by one; a replacement
                    // drops only the lead byte, after its last output byte.
                    if (!r_repl || r_grp == 3'd1) begin
                        n_win[0] = r_win[1];
                        n_win[1] = r_win[2];
                        n_win[2] = r_win[3];
                        n_cnt    = r_cnt - 3'd1;
                    end
                    n_grp = r_grp - 3'd1;
                    if (r_grp == 3'd1) begin
                        n_state = utf8s_pkg::S_CHECK;
                    end
                end
            end
            default: begin
                n_state = utf8s_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= utf8s_pkg::S_IDLE;
            r_cnt    <= 3'd0;
            r_last   <= 1'b0;
            r_grp    <= 3'd0;
            r_repl   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_last   <= n_last;
            r_grp    <= n_grp;
            r_repl   <= n_repl;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win   <= n_win;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end

    // An emit sequence always has bytes left to send.
    `U8S_ASSERT_NOW(a_emit_grp_nonzero, r_state == utf8s_pkg::S_EMIT, r_grp != 3'd0, "empty emit group")
    // Original bytes being passed on must all be present in the window.
    `U8S_ASSERT_NOW(a_pass_in_window, r_state == utf8s_pkg::S_EMIT && !r_repl, r_cnt >= r_grp, "pass group exceeds window")
    // Once a string has ended and the block is idle, nothing is left pending.
    `U8S_ASSERT_NOW(a_end_flushes, r_state == utf8s_pkg::S_IDLE && r_last, r_cnt == 3'd0, "bytes left after end of string")
    // An idle window never holds a complete four-byte load.
    `U8S_ASSERT_NOW(a_idle_room, r_state == utf8s_pkg::S_IDLE, r_cnt <= 3'd3, "no room for next byte")
    // An accepted byte is checked in the following cycle.
    `U8S_ASSERT_NEXT(a_accept_check, i_in.valid && i_in.ready, r_state == utf8s_pkg::S_CHECK, "accepted byte not checked")

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf8_sanitizer: a table of directed bytes, then random strings.
// Depends on utf8s_pkg and the utf8s_in_if / utf8s_out_if stream interfaces.

module testbench;

    // Random stimulus stops once this many bytes have been sent after the table.
    localparam int RANDOM_BYTES   = 390;
    // Length of the deliberate receiver hold-off, in cycles.
    localparam int LONG_HOLD      = 400;
    // Wait after the expected output has drained, so that any stray byte is caught.
    localparam int DRAIN_CYCLES   = 40;
    // Cycles without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_text_byte;

    // Length of the sequence a lead byte opens (0 when the lead is illegal),
    // and the range its second byte must fall in.
    typedef struct packed {
        logic [2:0] len;
        logic [7:0] lo;
        logic [7:0] hi;
    } t_seq_rule;

    // One row of the directed table. Where n_known is non-zero the expected
    // output is typed in (first byte in the top bits of known); otherwise it
    // comes from the predictor.
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [1:0]  n_known;
        logic [23:0] known;
    } t_stim_row;

    logic clk = 1'b0;
    logic rst_n;

    utf8s_in_if  in_bus ();
    utf8s_out_if out_bus ();

    utf8_sanitizer uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Predictor state: bytes of a sequence still waiting for its tail.
    logic [7:0] held_bytes [3];
    int         held_count = 0;

    t_text_byte step_results [$];   // output caused by the byte just taken
    t_text_byte expected_text [$];  // output still owed by the block, oldest first
    t_stim_row  directed_rows [$];
    logic [7:0] text_bytes [$];     // the random string being sent

    int n_mismatches = 0;
    bit calm         = 1'b0;        // no idling on either side while set
    bit rx_long_hold = 1'b0;        // asks the receiver for one long hold-off

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic t_seq_rule seq_rule(input logic [7:0] lead);
        t_seq_rule r;
        r.len = 3'd0;
        r.lo  = utf8s_pkg::CONT_LO;
        r.hi  = utf8s_pkg::CONT_HI;
        if (!lead[7]) begin
            r.len = 3'd1;
        end else if (lead[7:5] == 3'b110) begin
            // C0 and C1 could only encode overlong forms of ASCII.
            r.len = (lead[4:1] != 4'd0) ? 3'd2 : 3'd0;
        end else if (lead[7:4] == 4'he) begin
            r.len = 3'd3;
            if (lead == 8'he0) r.lo = 8'ha0;  // below A0 would be overlong
            if (lead == 8'hed) r.hi = 8'h9f;  // above 9F would be a surrogate
        end else if (lead[7:3] == 5'b11110 && lead[2:0] <= 3'd4) begin
            r.len = 3'd4;
            if (lead == 8'hf0) r.lo = 8'h90;  // below 90 would be overlong
            if (lead == 8'hf4) r.hi = 8'h8f;  // above 8F would pass U+10FFFF
        end
        return r;
    endfunction

    function automatic logic not_cont(input logic [7:0] b);
        return (b < utf8s_pkg::CONT_LO) || (b > utf8s_pkg::CONT_HI);
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        t_text_byte t;
        t.data = b;
        t.last = 1'b0;
        step_results.push_back(t);
    endfunction

    // Works out what the block sends for one input byte, given the bytes it
    // already holds, and updates the held bytes.
    function automatic void sanitize_step(input logic [7:0] b, input logic l);
        logic [7:0] win [4];
        int         n;
        int         pos;
        int         avail;
        int         k;
        t_seq_rule  r;
        logic       bad;
        logic       stop;
        step_results.delete();
        n = 0;
        for (k = 0; k < held_count; k++) begin
            win[n] = held_bytes[k];
            n++;
        end
        win[n] = b;
        n++;
        pos  = 0;
        stop = 1'b0;
        while (pos < n && !stop) begin
            avail = n - pos;
            r     = seq_rule(win[pos]);
            bad   = (r.len == 3'd0);
            // Whatever part of the sequence is present must already be legal.
            if (!bad && r.len >= 2 && avail >= 2)
                bad = (win[pos + 1] < r.lo) || (win[pos + 1] > r.hi);
            if (!bad && r.len >= 3 && avail >= 3)
                bad = not_cont(win[pos + 2]);
            if (!bad && r.len >= 4 && avail >= 4)
                bad = not_cont(win[pos + 3]);
            if (!bad && avail < int'(r.len) && !l) begin
                stop = 1'b1;  // legal so far, wait for the rest
            end else if (bad || avail < int'(r.len)) begin
                // Only the lead is replaced; what follows is scanned afresh.
                emit_byte(utf8s_pkg::REPL_B0);
                emit_byte(utf8s_pkg::REPL_B1);
                emit_byte(utf8s_pkg::REPL_B2);
                pos++;
            end else begin
                for (k = 0; k < int'(r.len); k++)
                    emit_byte(win[pos + k]);
                pos += int'(r.len);
            end
        end
        held_count = n - pos;
        for (k = 0; k < held_count; k++)
            held_bytes[k] = win[pos + k];
        if (l && step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_stim_row stim_row(input logic [7:0] d, input logic l,
                                           input logic [1:0] n_known = 2'd0,
                                           input logic [23:0] known = 24'd0);
        t_stim_row s;
        s.data    = d;
        s.last    = l;
        s.n_known = n_known;
        s.known   = known;
        return s;
    endfunction

    // Appends one character to the random string. Most are well formed with
    // random content; the rest are stray bytes, cut-short sequences, sequences
    // with a damaged continuation, and leads whose second byte has a narrow range.
    function automatic void append_char();
        logic [7:0] seq [4];
        int         kind;
        int         len;
        int         cut;
        int         k;
        kind = $urandom_range(0, 99);
        len  = $urandom_range(1, 4);
        case (len)
            1:       seq[0] = 8'($urandom_range(8'h00, 8'h7f));
            2:       seq[0] = 8'($urandom_range(8'hc2, 8'hdf));
            3:       seq[0] = 8'($urandom_range(8'he0, 8'hef));
            default: seq[0] = 8'($urandom_range(8'hf0, 8'hf4));
        endcase
        for (k = 1; k < 4; k++)
            seq[k] = 8'($urandom_range(8'h80, 8'hbf));
        case (seq[0])
            8'he0:   seq[1] = 8'($urandom_range(8'ha0, 8'hbf));
            8'hed:   seq[1] = 8'($urandom_range(8'h80, 8'h9f));
            8'hf0:   seq[1] = 8'($urandom_range(8'h90, 8'hbf));
            8'hf4:   seq[1] = 8'($urandom_range(8'h80, 8'h8f));
            default: ;
        endcase
        cut = len;
        if (kind < 8) begin
            seq[0] = 8'($urandom_range(0, 255));
            cut    = 1;
        end else if (kind < 18) begin
            cut = (len > 1) ? $urandom_range(1, len - 1) : 1;
        end else if (kind < 26) begin
            if (len > 1)
                seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
        end else if (kind >= 90) begin
            // Overlong, surrogate and out-of-range boundaries, about half illegal.
            k = $urandom_range(0, 3);
            seq[0] = (k == 0) ? 8'he0 : (k == 1) ? 8'hed : (k == 2) ? 8'hf0 : 8'hf4;
            seq[1] = 8'($urandom_range(8'h80, 8'hbf));
            len    = seq[0][4] ? 4 : 3;
            cut    = len;
        end
        for (k = 0; k < cut; k++)
            text_bytes.push_back(seq[k]);
    endfunction

    // Offers one byte after a random gap and returns at the edge on which it
    // is transferred, leaving valid high. The expected output is queued then.
    task automatic send_byte(input logic [7:0] b, input logic l,
                             input logic [1:0] n_known = 2'd0,
                             input logic [23:0] known = 24'd0);
        int         gap;
        int         k;
        t_text_byte t;
        gap = pick_gap();
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.in_byte <= b;
        in_bus.in_last <= l;
        // Nothing moves between the falling and the rising edge, so ready seen
        // at the falling edge decides the transfer at the next rising edge.
        do @(negedge clk); while (in_bus.ready !== 1'b1);
        @(posedge clk);
        sanitize_step(b, l);
        if (n_known == 2'd0) begin
            foreach (step_results[j])
                expected_text.push_back(step_results[j]);
        end else begin
            for (k = 0; k < int'(n_known); k++) begin
                t.data = known[23 - 8 * k -: 8];
                t.last = l && (k == int'(n_known) - 1);
                expected_text.push_back(t);
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns  mismatch: %s", $time, what);
        n_mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    initial begin
        int sent;
        int n_chars;
        bit hold_done;
        bit pause_done;
        sent       = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        in_bus.valid   <= 1'b0;
        in_bus.in_byte <= 8'h00;
        in_bus.in_last <= 1'b0;
        rst_n          <= 1'b0;

        // Directed table. Each group starts with nothing held, so the first
        // rows can have their output typed in.
        directed_rows.push_back(stim_row(8'h00, 1'b0, 2'd1, 24'h000000));
        directed_rows.push_back(stim_row(8'h7f, 1'b1, 2'd1, {8'h7f, 16'h0000}));
        // Bytes that can never start a sequence are replaced at once.
        directed_rows.push_back(stim_row(8'hff, 1'b0, 2'd3,
            {utf8s_pkg::REPL_B0, utf8s_pkg::REPL_B1, utf8s_pkg::REPL_B2}));
        directed_rows.push_back(stim_row(8'hc0, 1'b0, 2'd3,
            {utf8s_pkg::REPL_B0, utf8s_pkg::REPL_B1, utf8s_pkg::REPL_B2}));
        directed_rows.push_back(stim_row(8'hf5, 1'b0, 2'd3,
            {utf8s_pkg::REPL_B0, utf8s_pkg::REPL_B1, utf8s_pkg::REPL_B2}));
        // Legal two-byte sequences at both ends of the lead range.
        directed_rows.push_back(stim_row(8'hc2, 1'b0));
        directed_rows.push_back(stim_row(8'h80, 1'b0));
        directed_rows.push_back(stim_row(8'hdf, 1'b0));
        directed_rows.push_back(stim_row(8'hbf, 1'b0));
        // Overlong three-byte form: the bad second byte is seen before the
        // sequence is complete, and is then itself a stray continuation.
        directed_rows.push_back(stim_row(8'he0, 1'b0));
        directed_rows.push_back(stim_row(8'h9f, 1'b0));
        // Surrogate.
        directed_rows.push_back(stim_row(8'hed, 1'b0));
        directed_rows.push_back(stim_row(8'ha0, 1'b0));
        // Beyond U+10FFFF.
        directed_rows.push_back(stim_row(8'hf4, 1'b0));
        directed_rows.push_back(stim_row(8'h90, 1'b0));
        // Smallest legal four-byte sequence.
        directed_rows.push_back(stim_row(8'hf0, 1'b0));
        directed_rows.push_back(stim_row(8'h90, 1'b0));
        directed_rows.push_back(stim_row(8'h80, 1'b0));
        directed_rows.push_back(stim_row(8'h80, 1'b0));
        // Broken third byte on the last byte of a string.
        directed_rows.push_back(stim_row(8'he1, 1'b0));
        directed_rows.push_back(stim_row(8'h80, 1'b0));
        directed_rows.push_back(stim_row(8'h41, 1'b1));
        // String ends while a four-byte sequence is still short.
        directed_rows.push_back(stim_row(8'hf3, 1'b0));
        directed_rows.push_back(stim_row(8'h80, 1'b0));
        directed_rows.push_back(stim_row(8'h80, 1'b1));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].last,
                      directed_rows[i].n_known, directed_rows[i].known);

        // Random strings, each closed by a last-marked byte.
        while (sent < RANDOM_BYTES) begin
            calm = ($urandom_range(0, 99) < 15);
            text_bytes.delete();
            n_chars = $urandom_range(1, 10);
            repeat (n_chars) append_char();

            // Let the receiver stall for a long time while bytes keep coming,
            // so that the block fills and refuses input.
            if (!hold_done && sent >= 120) begin
                rx_long_hold = 1'b1;
                hold_done    = 1'b1;
            end
            // Once, let the block run completely dry before going on.
            if (!pause_done && sent >= 280) begin
                in_bus.valid <= 1'b0;
                do @(posedge clk); while (expected_text.size() != 0);
                pause_done = 1'b1;
            end

            foreach (text_bytes[i])
                send_byte(text_bytes[i], i == text_bytes.size() - 1);
            sent += text_bytes.size();
        end

        in_bus.valid <= 1'b0;
        do @(posedge clk); while (expected_text.size() != 0);
        // Anything sent after this point is caught as unexpected.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: one decision per rising edge, so ready gets a single update
    // in each time step. Stalls start at random unless the stimulus is calm.
    // ------------------------------------------------------------------

    initial begin
        int stall_left;
        stall_left = 0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_long_hold) begin
                rx_long_hold = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0) begin
                out_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                out_bus.ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Output checking, sampled at the falling edge ahead of each transfer.
    // ------------------------------------------------------------------

    always @(negedge clk) begin
        t_text_byte want;
        if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
            if (expected_text.size() == 0) begin
                report_mismatch($sformatf("byte %02h last %0b with nothing expected",
                                          out_bus.out_byte, out_bus.out_last));
            end else begin
                want = expected_text.pop_front();
                if (out_bus.out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              out_bus.out_byte, want.data));
                if (out_bus.out_last !== want.last)
                    report_mismatch($sformatf("out_last %0b on byte %02h, expected %0b",
                                              out_bus.out_last, want.data, want.last));
            end
        end
    end

    // Watchdog: too many cycles in a row without a transfer on either side.
    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(negedge clk);
            if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
                (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
                idle = 0;
            else
                idle++;
        end
        $display("%0t ns  no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
